[src/piecewise_linear_curve_lookup_top_macros.svh]
// Assertion macros for the piecewise-linear curve lookup block.
// Needs nothing else; the top level includes it by file name.
`ifndef PIECEWISE_LINEAR_CURVE_LOOKUP_TOP_MACROS_SVH
`define PIECEWISE_LINEAR_CURVE_LOOKUP_TOP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define PLCL_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
	else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define PLCL_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
	else $error(msg);
`else
`define PLCL_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg)
`define PLCL_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif
`endif

[src/plcl_pkg.sv]
// Package for the piecewise-linear curve lookup: field widths, reset values,
// register and command codes, and the sequencer state type. No dependencies.
package plcl_pkg;

	// Defaults for the top-level parameters.
	localparam int unsigned DEF_MAX_SEGMENTS = 32;
	localparam int unsigned DEF_X_WIDTH      = 12;

	// Fixed field and register widths.
	localparam int unsigned NSEG_W    = 6;
	localparam int unsigned MX_W      = 12;
	localparam int unsigned MY_W      = 16;
	localparam int unsigned PCT_W     = 7;
	localparam int unsigned IDX_W     = 6;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;

	// Full scale of a breakpoint percentage.
	localparam int unsigned PCT_FULL = 100;

	// Weighted breakpoint sum, scaled numerator, and iteration counter widths.
	localparam int unsigned ACC_W = PCT_W + MX_W;
	localparam int unsigned NUM_W = ACC_W + MY_W;
	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	// Register reset values.
	localparam logic [NSEG_W-1:0] RST_NUM_SEGMENTS = NSEG_W'(10);
	localparam logic [MX_W-1:0]   RST_MAX_X        = MX_W'(100);
	localparam logic [MY_W-1:0]   RST_MAX_Y        = MY_W'(100);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_SEGMENTS = 2'd0,
		REG_MAX_X        = 2'd1,
		REG_MAX_Y        = 2'd2
	} cfg_reg_t;

	// Input commands.
	typedef enum logic [0:0] {
		CMD_WRITE = 1'b0,
		CMD_EVAL  = 1'b1
	} cmd_t;

	// Evaluation sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_SEG,
		ST_DIV_SEG,
		ST_RD_LO,
		ST_RD_HI,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_MUL_Y,
		ST_DIV_Y,
		ST_FINISH
	} state_t;

endpackage

[src/piecewise_linear_curve_lookup_top.sv]
// Top level of the piecewise-linear curve lookup; uses plcl_pkg and the
// assertion macros in piecewise_linear_curve_lookup_top_macros.svh.
//
// Usage: the input channel (in_valid/in_ready) carries one transaction per
// command. A write (cmd 0) stores one clamped breakpoint percentage if its index
// is at most the effective segment count, and gives no result. An evaluate (cmd 1)
// returns one y_value/x_clamped transaction on the output channel (out_valid/out_ready).
// Timing: an evaluate runs through one shared bit-serial shift-add multiplier
// and one restoring divider, one bit per cycle; the next command is taken in
// the cycle after the result is handed to the output register.
// Reset clears the configuration to 10 segments, max_x 100 and max_y 100, and
// marks all breakpoints as zero through per-entry flags; no clearing pass is
// needed. If the receiver stalls, the finished result waits in the output
// register while new commands are still accepted; a second evaluate waits in
// its final state until that register frees up.
// Configuration must be written through cfg_wr_en/cfg_index/cfg_data only while idle; the block does not enforce it.
`include "piecewise_linear_curve_lookup_top_macros.svh"

module piecewise_linear_curve_lookup_top import plcl_pkg::*; #(
	parameter int unsigned MAX_SEGMENTS = DEF_MAX_SEGMENTS,
	parameter int unsigned X_WIDTH      = DEF_X_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port.
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// Command channel.
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd,
	input  logic [IDX_W-1:0]     point_index,
	input  logic [PCT_W-1:0]     point_value,
	input  logic [X_WIDTH-1:0]   x_value,
	// Result channel.
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [MY_W-1:0]      y_value,
	output logic                 x_clamped
);

	localparam int unsigned DEPTH  = MAX_SEGMENTS + 1;
	localparam int unsigned SEG_W  = $clog2(DEPTH);
	localparam int unsigned PROD_W = MX_W + SEG_W;
	localparam int unsigned CMP_W  = (X_WIDTH > MX_W) ? X_WIDTH : MX_W;
	localparam int unsigned MPL_W  = MY_W;

	// Configuration registers.
	logic [NSEG_W-1:0] num_segments_q;
	logic [MX_W-1:0]   max_x_q;
	logic [MY_W-1:0]   max_y_q;

	// Sequencer and datapath registers.
	state_t            state_q, state_nx;
	logic [CNT_W-1:0]  cnt_q;
	logic [NUM_W-1:0]  mcand_q;
	logic [MPL_W-1:0]  mplier_q;
	logic [NUM_W-1:0]  sum_q;
	logic [NUM_W-1:0]  div_num_q;
	logic [ACC_W:0]    div_rem_q;
	logic [ACC_W-1:0]  div_den_q;
	logic [SEG_W-1:0]  seg_q;
	logic [MX_W-1:0]   rem_q;
	logic              clamp_q;

	// Breakpoint memory with per-entry written flags.
	logic [PCT_W-1:0]  mem_q [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [PCT_W-1:0]  rd_data_q;
	logic              rd_vld_q;

	// Output register.
	logic              out_valid_q;
	logic [MY_W-1:0]   y_q;
	logic              xc_q;

	// Combinational signals.
	logic [SEG_W-1:0]  nseg_eff;
	logic [MX_W-1:0]   mx_eff;
	logic [ACC_W-1:0]  den_y;
	logic              x_over;
	logic [MX_W-1:0]   x_eff;
	logic [PCT_W-1:0]  wr_val;
	logic              wr_ok;
	logic [SEG_W-1:0]  wr_addr;
	logic              accept;
	logic              wr_fire;
	logic              ev_fire;
	logic              last;
	logic              rd_en;
	logic [SEG_W-1:0]  rd_addr;
	logic [SEG_W-1:0]  seg_hi;
	logic [PCT_W-1:0]  rd_val;
	logic              fin_load;
	logic [NUM_W-1:0]  sum_nx;
	logic [ACC_W:0]    rem_sh;
	logic              q_bit;
	logic [ACC_W:0]    rem_nx;
	logic [NUM_W-1:0]  num_nx;
	logic [MY_W-1:0]   y_sat;

	// Configuration writes; an unknown index is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_segments_q <= RST_NUM_SEGMENTS;
			max_x_q        <= RST_MAX_X;
			max_y_q        <= RST_MAX_Y;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_NUM_SEGMENTS: num_segments_q <= cfg_data[NSEG_W-1:0];
				REG_MAX_X:        max_x_q        <= cfg_data[MX_W-1:0];
				REG_MAX_Y:        max_y_q        <= cfg_data[MY_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective segment count and max_x, and the final divisor 100 * max_x.
	always_comb begin
		if (num_segments_q == '0) begin
			nseg_eff = SEG_W'(1);
		end else if (32'(num_segments_q) > MAX_SEGMENTS) begin
			nseg_eff = SEG_W'(MAX_SEGMENTS);
		end else begin
			nseg_eff = SEG_W'(num_segments_q);
		end
	end

	assign mx_eff = (max_x_q == '0) ? MX_W'(1) : max_x_q;
	assign den_y  = ACC_W'(32'(mx_eff) * PCT_FULL);

	// Command decode, x clamping and breakpoint write checks.
	assign accept  = in_valid && in_ready;
	assign wr_fire = accept && (cmd == CMD_WRITE);
	assign ev_fire = accept && (cmd == CMD_EVAL);
	assign x_over  = CMP_W'(x_value) > CMP_W'(mx_eff);
	assign x_eff   = x_over ? mx_eff : MX_W'(x_value);
	assign wr_val  = (point_value > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : point_value;
	assign wr_ok   = 32'(point_index) <= 32'(nseg_eff);
	assign wr_addr = SEG_W'(point_index);

	// Shared shift-add step and restoring division step.
	assign sum_nx = mplier_q[0] ? (sum_q + mcand_q) : sum_q;
	assign rem_sh = {div_rem_q[ACC_W-1:0], div_num_q[NUM_W-1]};
	assign q_bit  = rem_sh >= {1'b0, div_den_q};
	assign rem_nx = q_bit ? (rem_sh - {1'b0, div_den_q}) : rem_sh;
	assign num_nx = {div_num_q[NUM_W-2:0], q_bit};
	assign last   = (cnt_q == CNT_W'(1));

	// Upper breakpoint address; at the last breakpoint the remainder is zero.
	assign seg_hi = (seg_q == SEG_W'(MAX_SEGMENTS)) ? seg_q : (seg_q + SEG_W'(1));
	assign rd_val = rd_vld_q ? rd_data_q : '0;

	// Saturated result from the final quotient.
	assign y_sat = (|div_num_q[NUM_W-1:MY_W]) ? '1 : div_num_q[MY_W-1:0];

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next-state logic.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:    if (ev_fire) state_nx = ST_MUL_SEG;
			ST_MUL_SEG: if (last) state_nx = ST_DIV_SEG;
			ST_DIV_SEG: if (last) state_nx = ST_RD_LO;
			ST_RD_LO:   state_nx = ST_RD_HI;
			ST_RD_HI:   state_nx = ST_MUL_LO;
			ST_MUL_LO:  if (last) state_nx = ST_MUL_HI;
			ST_MUL_HI:  if (last) state_nx = ST_MUL_Y;
			ST_MUL_Y:   if (last) state_nx = ST_DIV_Y;
			ST_DIV_Y:   if (last) state_nx = ST_FINISH;
			ST_FINISH:  if (!out_valid_q || out_ready) state_nx = ST_IDLE;
			default:    state_nx = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = seg_q;
		fin_load = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_RD_LO:  rd_en = 1'b1;
			ST_RD_HI: begin
				rd_en   = 1'b1;
				rd_addr = seg_hi;
			end
			ST_FINISH: fin_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// Breakpoint storage and its registered read port.
	always_ff @(posedge clk) begin
		if (wr_fire && wr_ok) begin
			mem_q[wr_addr] <= wr_val;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Written flags: an entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_fire && wr_ok) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// Datapath: serial multiplies and divides, loaded at the end of each step.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (ev_fire) begin
					clamp_q  <= x_over;
					mcand_q  <= NUM_W'(x_eff);
					mplier_q <= MPL_W'(nseg_eff);
					sum_q    <= '0;
					cnt_q    <= CNT_W'(SEG_W);
				end
			end
			ST_MUL_SEG, ST_MUL_LO, ST_MUL_HI, ST_MUL_Y: begin
				if (!last) begin
					sum_q    <= sum_nx;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q - CNT_W'(1);
				end else begin
					case (state_q)
						ST_MUL_SEG: begin
							// Product x * segments, left aligned for the divider.
							div_num_q <= sum_nx << (NUM_W - PROD_W);
							div_rem_q <= '0;
							div_den_q <= ACC_W'(mx_eff);
							cnt_q     <= CNT_W'(PROD_W);
						end
						ST_MUL_LO: begin
							// Add the upper breakpoint weighted by the remainder.
							sum_q    <= sum_nx;
							mcand_q  <= NUM_W'(rem_q);
							mplier_q <= MPL_W'(rd_val);
							cnt_q    <= CNT_W'(PCT_W);
						end
						ST_MUL_HI: begin
							// Scale the weighted sum by max_y.
							mcand_q  <= sum_nx;
							mplier_q <= max_y_q;
							sum_q    <= '0;
							cnt_q    <= CNT_W'(MY_W);
						end
						default: begin
							// Divide the scaled sum by 100 * max_x.
							div_num_q <= sum_nx;
							div_rem_q <= '0;
							div_den_q <= den_y;
							cnt_q     <= CNT_W'(NUM_W);
						end
					endcase
				end
			end
			ST_DIV_SEG, ST_DIV_Y: begin
				div_num_q <= num_nx;
				div_rem_q <= rem_nx;
				cnt_q     <= cnt_q - CNT_W'(1);
				if (last && (state_q == ST_DIV_SEG)) begin
					seg_q <= SEG_W'(num_nx);
					rem_q <= MX_W'(rem_nx);
				end
			end
			ST_RD_HI: begin
				// Lower breakpoint weighted by max_x minus the remainder.
				mcand_q  <= NUM_W'(mx_eff - rem_q);
				mplier_q <= MPL_W'(rd_val);
				sum_q    <= '0;
				cnt_q    <= CNT_W'(PCT_W);
			end
			default: ;
		endcase
	end

	// Output register: loads when free or being emptied in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			y_q  <= y_sat;
			xc_q <= clamp_q;
		end
	end

	assign out_valid = out_valid_q;
	assign y_value   = y_q;
	assign x_clamped = xc_q;

	// The segment split must leave an index within range and a proper remainder.
	`PLCL_ASSERT_IMP(a_seg_split, clk, arst_n, state_q == ST_RD_LO, (rem_q < mx_eff) && (seg_q <= nseg_eff), "segment index or remainder out of range")
	// The final quotient never needs saturation, since breakpoints stay at or below 100.
	`PLCL_ASSERT_IMP(a_quot_fits, clk, arst_n, state_q == ST_FINISH, div_num_q[NUM_W-1:MY_W] == '0, "final quotient exceeds the output width")
	// A delivered result never exceeds the full-scale output.
	`PLCL_ASSERT_IMP(a_y_bound, clk, arst_n, out_valid_q, y_q <= max_y_q, "result above max_y")
	// An accepted breakpoint write marks its entry as written.
	`PLCL_ASSERT_NXT(a_wr_mark, clk, arst_n, wr_fire && wr_ok, vld_q[$past(wr_addr)], "written breakpoint not marked")

endmodule
